[rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int MEM_DEPTH  = 2 * (2 ** IDX_W);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 104;

    localparam logic       KIND_TRADE  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_RESTED  = 3'd0;
    localparam logic [2:0] ST_FILLED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    typedef struct packed {
        logic [31:0]      price;
        logic [31:0]      qty;
        logic [IDX_W-1:0] next;
    } t_node;

endpackage

`default_nettype wire

[rtl/limit_order_book_matcher_core.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority matcher over a two-sided book kept as sorted linked
// lists in one node memory.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  s_axis    in         tdata {quantity, price, side}, tuser {order_kind}
//  m_axis    out        tdata {remaining_qty, status, trade_qty, trade_price},
//                       tuser {item_kind}, tlast {last}
//
// One order is taken at a time. Matching reads the opposite side from
// its head through the single read port of the node memory. Resting a
// remainder walks past the orders on its own side that keep priority.
// Reset clears the state, output valid, counts and list pointers only.
// A stalled output holds the sequencer in any step that emits a word.
`default_nettype none

module limit_order_book_matcher_core
    import lobm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // side [0], price [32:1], quantity [64:33], zero pad [71:65]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // order_kind [0]
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // trade_price [31:0], trade_qty [63:32], status [66:64],
    // remaining_qty [98:67], zero pad [103:99]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // item_kind [0]
    output logic                       o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_FIN    = 3'd2;
    localparam logic [2:0] S_FREERD = 3'd3;
    localparam logic [2:0] S_WSTART = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;
    localparam logic [2:0] S_INS    = 3'd6;
    localparam logic [2:0] S_LINK   = 3'd7;

    t_node r_mem [MEM_DEPTH];
    t_node r_rd;

    logic [2:0]       r_state, n_state;
    logic             r_sell, n_sell;
    logic             r_mkt, n_mkt;
    logic             r_zero, n_zero;
    logic [31:0]      r_price, n_price;
    logic [31:0]      r_rem, n_rem;
    logic [IDX_W-1:0] r_head [2];
    logic [IDX_W-1:0] n_head [2];
    logic [IDX_W-1:0] r_free [2];
    logic [IDX_W-1:0] n_free [2];
    logic [CNT_W-1:0] r_fill [2];
    logic [CNT_W-1:0] n_fill [2];
    logic [CNT_W-1:0] r_cnt [2];
    logic [CNT_W-1:0] n_cnt [2];
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_new, n_new;
    logic [IDX_W-1:0] r_prev_idx, n_prev_idx;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_has_prev, n_has_prev;
    t_node            r_prev, n_prev;

    logic             r_ovld, n_ovld;
    logic             r_okind, n_okind;
    logic [31:0]      r_oprice, n_oprice;
    logic [31:0]      r_oqty, n_oqty;
    logic [2:0]       r_ostat, n_ostat;
    logic [31:0]      r_orem, n_orem;

    logic             rd_en, wr_en;
    logic [IDX_W:0]   rd_addr, wr_addr;
    t_node            wr_data;
    logic             slot, own, opp, after, in_side;
    logic [31:0]      t_qty, left_qty, rest_qty;

    assign slot    = !r_ovld || i_m_axis_tready;
    assign own     = r_sell;
    assign opp     = !r_sell;
    assign in_side = i_s_axis_tdata[0];
    assign t_qty   = (r_rem < r_rd.qty) ? r_rem : r_rd.qty;
    assign left_qty = r_rem - t_qty;
    assign rest_qty = r_rd.qty - t_qty;
    assign after   = r_sell ? (r_rd.price <= r_price) : (r_rd.price >= r_price);

    always_comb begin
        n_state    = r_state;
        n_sell     = r_sell;
        n_mkt      = r_mkt;
        n_zero     = r_zero;
        n_price    = r_price;
        n_rem      = r_rem;
        n_head     = r_head;
        n_free     = r_free;
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_new      = r_new;
        n_prev_idx = r_prev_idx;
        n_k        = r_k;
        n_has_prev = r_has_prev;
        n_prev     = r_prev;
        n_ovld     = r_ovld && !i_m_axis_tready;
        n_okind    = r_okind;
        n_oprice   = r_oprice;
        n_oqty     = r_oqty;
        n_ostat    = r_ostat;
        n_orem     = r_orem;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_rd;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_sell  = in_side;
                    n_price = i_s_axis_tdata[32:1];
                    n_rem   = i_s_axis_tdata[64:33];
                    n_mkt   = i_s_axis_tuser;
                    n_zero  = (i_s_axis_tdata[64:33] == '0);
                    if (i_s_axis_tdata[64:33] == '0 || r_cnt[!in_side] == '0) begin
                        n_state = S_FIN;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {!in_side, r_head[!in_side]};
                        n_state = S_MATCH;
                    end
                end
            end
            S_MATCH: begin
                if (!r_mkt && (r_sell ? (r_price > r_rd.price) : (r_price < r_rd.price))) begin
                    n_state = S_FIN;
                end else if (slot) begin
                    n_ovld   = 1'b1;
                    n_okind  = KIND_TRADE;
                    n_oprice = r_rd.price;
                    n_oqty   = t_qty;
                    n_ostat  = ST_RESTED;
                    n_orem   = left_qty;
                    n_rem    = left_qty;
                    wr_en    = 1'b1;
                    wr_addr  = {opp, r_head[opp]};
                    n_state  = S_FIN;
                    if (rest_qty == '0) begin
                        wr_data      = '{price: r_rd.price, qty: '0, next: r_free[opp]};
                        n_free[opp]  = r_head[opp];
                        n_head[opp]  = r_rd.next;
                        n_cnt[opp]   = r_cnt[opp] - CNT_W'(1);
                        if (left_qty != '0 && r_cnt[opp] != CNT_W'(1)) begin
                            rd_en   = 1'b1;
                            rd_addr = {opp, r_rd.next};
                            n_state = S_MATCH;
                        end
                    end else begin
                        wr_data = '{price: r_rd.price, qty: rest_qty, next: r_rd.next};
                    end
                end
            end
            S_FIN: begin
                if (r_zero || r_rem == '0 || r_mkt || r_cnt[own] >= CNT_W'(BOOK_DEPTH)) begin
                    if (slot) begin
                        n_ovld   = 1'b1;
                        n_okind  = KIND_STATUS;
                        n_oprice = '0;
                        n_oqty   = '0;
                        n_orem   = r_rem;
                        n_state  = S_IDLE;
                        if (r_zero) begin
                            n_ostat = ST_ZERO;
                        end else if (r_rem == '0) begin
                            n_ostat = ST_FILLED;
                        end else if (r_mkt) begin
                            n_ostat = ST_DROPPED;
                        end else begin
                            n_ostat = ST_FULL;
                        end
                    end
                end else if (r_fill[own] == CNT_W'(BOOK_DEPTH)) begin
                    rd_en   = 1'b1;
                    rd_addr = {own, r_free[own]};
                    n_new   = r_free[own];
                    n_state = S_FREERD;
                end else begin
                    n_new       = r_fill[own][IDX_W-1:0];
                    n_fill[own] = r_fill[own] + CNT_W'(1);
                    n_state     = S_WSTART;
                end
            end
            S_FREERD: begin
                n_free[own] = r_rd.next;
                n_state     = S_WSTART;
            end
            S_WSTART: begin
                n_has_prev = 1'b0;
                n_k        = '0;
                n_cur      = r_head[own];
                if (r_cnt[own] == '0) begin
                    n_state = S_INS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {own, r_head[own]};
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (after) begin
                    n_has_prev = 1'b1;
                    n_prev     = r_rd;
                    n_prev_idx = r_cur;
                    n_k        = r_k + CNT_W'(1);
                    if ((r_k + CNT_W'(1)) == r_cnt[own]) begin
                        n_state = S_INS;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {own, r_rd.next};
                        n_cur   = r_rd.next;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (r_has_prev || slot) begin
                    wr_en   = 1'b1;
                    wr_addr = {own, r_new};
                    wr_data = '{price: r_price, qty: r_rem, next: r_cur};
                    if (r_has_prev) begin
                        n_state = S_LINK;
                    end else begin
                        n_head[own] = r_new;
                    end
                end
            end
            S_LINK: begin
                if (slot) begin
                    wr_en   = 1'b1;
                    wr_addr = {own, r_prev_idx};
                    wr_data = '{price: r_prev.price, qty: r_prev.qty, next: r_new};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if ((r_state == S_INS && !r_has_prev && slot) || (r_state == S_LINK && slot)) begin
            n_cnt[own] = r_cnt[own] + CNT_W'(1);
            n_ovld     = 1'b1;
            n_okind    = KIND_STATUS;
            n_oprice   = '0;
            n_oqty     = '0;
            n_ostat    = ST_RESTED;
            n_orem     = r_rem;
            n_state    = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_head  <= '{default: '0};
            r_free  <= '{default: '0};
            r_fill  <= '{default: '0};
            r_cnt   <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_head  <= n_head;
            r_free  <= n_free;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sell     <= n_sell;
        r_mkt      <= n_mkt;
        r_zero     <= n_zero;
        r_price    <= n_price;
        r_rem      <= n_rem;
        r_cur      <= n_cur;
        r_new      <= n_new;
        r_prev_idx <= n_prev_idx;
        r_k        <= n_k;
        r_has_prev <= n_has_prev;
        r_prev     <= n_prev;
        r_okind    <= n_okind;
        r_oprice   <= n_oprice;
        r_oqty     <= n_oqty;
        r_ostat    <= n_ostat;
        r_orem     <= n_orem;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {5'd0, r_orem, r_ostat, r_oqty, r_oprice};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = (r_okind == KIND_STATUS);

endmodule

`default_nettype wire

[rtl/lobm_checker.sv]
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the limit order book matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_checker
    import lobm_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word dropped or changed while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == KIND_STATUS)))
        else $error("tlast does not match a status word");

    a_trade_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_TRADE |->
            o_m_axis_tdata[66:64] == ST_RESTED && o_m_axis_tdata[63:32] != '0)
        else $error("trade word with status or zero quantity");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_STATUS |->
            o_m_axis_tdata[66:64] <= ST_ZERO && o_m_axis_tdata[31:0] == '0)
        else $error("bad status word");

    a_one_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second order taken before the first finished");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (.*);

`default_nettype wire
